// ===== rtl/urb_pkg.sv =====
// urb_pkg: shared types, codes and sizing for the buffered UART ring block.
// No dependencies; imported by every module under rtl.
`timescale 1ns / 1ps
package urb_pkg;

   localparam int SLOTS = 32;
   localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [1:0] ACT_PUSH  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_TXRDY = 2'd2;
   localparam logic [1:0] ACT_RECV  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_TXFULL  = 2'd1;
   localparam logic [1:0] ST_RXEMPTY = 2'd2;
   localparam logic [1:0] ST_OVERRUN = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] read_byte;
      logic       line_send;
      logic [7:0] line_byte;
      logic       tx_busy;
   } rsp_type;

   typedef struct packed {
      logic exec;
      logic load;
   } cmd_type;

   function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] last;
      last = PTR_W'(SLOTS - 1);
      return (p == last) ? '0 : p + 1'b1;
   endfunction

endpackage

// ===== rtl/urb_ctrl.sv =====
// urb_ctrl: handshake sequencer (accept, load result, hold result).
// Depends on urb_pkg for the command struct.
`timescale 1ns / 1ps
module urb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output urb_pkg::cmd_type cmd
);
   import urb_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_LOAD = 3'b010,
      S_SEND = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_LOAD;
         S_LOAD: state_in = S_SEND;
         S_SEND: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_SEND);
   assign cmd.exec  = req_valid && (state_ff == S_IDLE);
   assign cmd.load  = (state_ff == S_LOAD);

endmodule

// ===== rtl/urb_dpath.sv =====
// urb_dpath: tx/rx ring memories, positions, transmit flag and result register.
// Depends on urb_pkg for types, codes and next_pos.
`timescale 1ns / 1ps
module urb_dpath (
   input  logic             clock,
   input  logic             reset,
   input  urb_pkg::cmd_type cmd,
   input  urb_pkg::req_type req_data,
   output urb_pkg::rsp_type rsp_data
);
   import urb_pkg::*;

   logic [7:0] tx_mem [SLOTS];
   logic [7:0] rx_mem [SLOTS];

   logic [PTR_W-1:0] tx_wp_ff, tx_wp_in, tx_rp_ff, tx_rp_in;
   logic [PTR_W-1:0] rx_wp_ff, rx_wp_in, rx_rp_ff, rx_rp_in;
   logic             active_ff, active_in;

   logic [1:0] status_ff, status_in;
   logic       take_rx_ff, take_rx_in;
   logic       send_ff, send_in;
   logic       take_tx_ff, take_tx_in;
   logic [7:0] byte_ff;
   logic [7:0] tx_rd_ff, rx_rd_ff;
   logic       tx_we, rx_we;
   rsp_type    rsp_ff, rsp_in;

   logic tx_full, tx_empty, rx_full, rx_empty;

   assign tx_full  = (next_pos(tx_wp_ff) == tx_rp_ff);
   assign tx_empty = (tx_rp_ff == tx_wp_ff);
   assign rx_full  = (next_pos(rx_wp_ff) == rx_rp_ff);
   assign rx_empty = (rx_rp_ff == rx_wp_ff);

   always_comb begin
      tx_wp_in   = tx_wp_ff;
      tx_rp_in   = tx_rp_ff;
      rx_wp_in   = rx_wp_ff;
      rx_rp_in   = rx_rp_ff;
      active_in  = active_ff;
      status_in  = ST_OK;
      take_rx_in = 1'b0;
      send_in    = 1'b0;
      take_tx_in = 1'b0;
      tx_we      = 1'b0;
      rx_we      = 1'b0;
      case (req_data.action)
         ACT_PUSH: begin
            if (tx_full) begin
               status_in = ST_TXFULL;
            end else begin
               tx_we    = 1'b1;
               tx_wp_in = next_pos(tx_wp_ff);
               if (!active_ff) begin
                  // idle transmitter has an empty ring: the pushed byte goes out now
                  active_in = 1'b1;
                  send_in   = 1'b1;
                  tx_rp_in  = next_pos(tx_rp_ff);
               end
            end
         end
         ACT_READ: begin
            if (rx_empty) begin
               status_in = ST_RXEMPTY;
            end else begin
               take_rx_in = 1'b1;
               rx_rp_in   = next_pos(rx_rp_ff);
            end
         end
         ACT_TXRDY: begin
            if (tx_empty) begin
               active_in = 1'b0;
            end else begin
               send_in    = 1'b1;
               take_tx_in = 1'b1;
               tx_rp_in   = next_pos(tx_rp_ff);
            end
         end
         ACT_RECV: begin
            if (rx_full) begin
               status_in = ST_OVERRUN;
            end else begin
               rx_we    = 1'b1;
               rx_wp_in = next_pos(rx_wp_ff);
            end
         end
         default: status_in = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_wp_ff  <= '0;
         tx_rp_ff  <= '0;
         rx_wp_ff  <= '0;
         rx_rp_ff  <= '0;
         active_ff <= 1'b0;
      end else if (cmd.exec) begin
         tx_wp_ff  <= tx_wp_in;
         tx_rp_ff  <= tx_rp_in;
         rx_wp_ff  <= rx_wp_in;
         rx_rp_ff  <= rx_rp_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff  <= status_in;
         take_rx_ff <= take_rx_in;
         send_ff    <= send_in;
         take_tx_ff <= take_tx_in;
         byte_ff    <= req_data.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && tx_we) tx_mem[tx_wp_ff] <= req_data.data_byte;
      if (cmd.exec)          tx_rd_ff <= tx_mem[tx_rp_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && rx_we) rx_mem[rx_wp_ff] <= req_data.data_byte;
      if (cmd.exec)          rx_rd_ff <= rx_mem[rx_rp_ff];
   end

   always_comb begin
      rsp_in.status    = status_ff;
      rsp_in.read_byte = take_rx_ff ? rx_rd_ff : 8'd0;
      rsp_in.line_send = send_ff;
      rsp_in.line_byte = !send_ff ? 8'd0 : (take_tx_ff ? tx_rd_ff : byte_ff);
      rsp_in.tx_busy   = active_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/uart_tx_rx_ring_buffer_top.sv =====
// uart_tx_rx_ring_buffer_top: buffered UART tx/rx rings, top level.
// Depends on urb_pkg, urb_ctrl and urb_dpath.
//
//   channel | ports                       | payload
//   req     | req_valid, req_ready        | req_data  (action, data_byte)
//   rsp     | rsp_valid, rsp_ready        | rsp_data  (status, read_byte,
//           |                             |  line_send, line_byte, tx_busy)
//
// One transfer in, one transfer out: each item passes accept, load and present,
// the load step covering the registered read of the ring memories.
// Synchronous reset empties both rings and clears the transmit flag.
// req_ready drops from acceptance until the result transfer completes;
// rsp stalls simply hold the result register.
`timescale 1ns / 1ps
module uart_tx_rx_ring_buffer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  urb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output urb_pkg::rsp_type rsp_data
);
   import urb_pkg::*;

   cmd_type cmd;

   urb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   urb_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ===== tb/sv/tb_uart_tx_rx_ring_buffer_top.sv =====
// Self-checking testbench for uart_tx_rx_ring_buffer_top: transmit and receive rings.
// Predicts every result transfer in-line and checks it field by field.
// Depends on urb_pkg and the RTL under rtl/.
`timescale 1ns / 1ps
module tb_uart_tx_rx_ring_buffer_top;
   import urb_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 10;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int MAX_REPORTS     = 10;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // predicted ring state
   logic [7:0]       tx_ring [SLOTS];
   logic [7:0]       rx_ring [SLOTS];
   logic [PTR_W-1:0] tx_wr = '0;
   logic [PTR_W-1:0] tx_rd = '0;
   logic [PTR_W-1:0] rx_wr = '0;
   logic [PTR_W-1:0] rx_rd = '0;
   logic             tx_active = 1'b0;
   rsp_type          uart_results_due [$];

   bit send_gaps_on     = 1'b1;
   bit rsp_stalls_on    = 1'b1;
   bit hold_off_request = 1'b0;
   int fail_count       = 0;
   int stalled_cycles   = 0;

   uart_tx_rx_ring_buffer_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [PTR_W-1:0] ring_step(input logic [PTR_W-1:0] pos);
      return (int'(pos) == SLOTS - 1) ? '0 : pos + 1'b1;
   endfunction

   function automatic rsp_type uart_step_outcome(input req_type item);
      rsp_type res;
      res = '0;
      res.status = ST_OK;
      case (item.action)
         ACT_PUSH: begin
            if (ring_step(tx_wr) == tx_rd) begin
               res.status = ST_TXFULL;
            end else begin
               tx_ring[tx_wr] = item.data_byte;
               tx_wr = ring_step(tx_wr);
               if (!tx_active) begin
                  tx_active     = 1'b1;
                  res.line_send = 1'b1;
                  res.line_byte = tx_ring[tx_rd];
                  tx_rd         = ring_step(tx_rd);
               end
            end
         end
         ACT_READ: begin
            if (rx_rd == rx_wr) begin
               res.status = ST_RXEMPTY;
            end else begin
               res.read_byte = rx_ring[rx_rd];
               rx_rd         = ring_step(rx_rd);
            end
         end
         ACT_TXRDY: begin
            if (tx_rd != tx_wr) begin
               res.line_send = 1'b1;
               res.line_byte = tx_ring[tx_rd];
               tx_rd         = ring_step(tx_rd);
            end else begin
               tx_active = 1'b0;
            end
         end
         ACT_RECV: begin
            if (ring_step(rx_wr) == rx_rd) begin
               res.status = ST_OVERRUN;
            end else begin
               rx_ring[rx_wr] = item.data_byte;
               rx_wr          = ring_step(rx_wr);
            end
         end
         default: res.status = ST_OK;
      endcase
      res.tx_busy = tx_active;
      return res;
   endfunction

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (uart_results_due.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: result transfer 0x%0h with none pending", $time, rsp_data);
            end else begin
               want = uart_results_due.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_data.status));
               compare_field("read_byte", 32'(want.read_byte), 32'(rsp_data.read_byte));
               compare_field("line_send", 32'(want.line_send), 32'(rsp_data.line_send));
               compare_field("line_byte", 32'(want.line_byte), 32'(rsp_data.line_byte));
               compare_field("tx_busy", 32'(want.tx_busy), 32'(rsp_data.tx_busy));
            end
         end
         if (req_valid && req_ready)
            uart_results_due.push_back(uart_step_outcome(req_data));
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stalled_cycles = 0;
      else
         stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : receiver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_left        = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if (rsp_stalls_on && $urandom_range(0, 9) == 0)
               stall_left = $urandom_range(1, 15);
         end
      end
   end

   // called and returns at a falling edge
   task automatic send_item(input logic [1:0] action, input logic [7:0] data_byte);
      if (send_gaps_on && $urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 15)) @(negedge clock);
      req_data.action    = action;
      req_data.data_byte = data_byte;
      req_valid          = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_random(input traffic_mix_type mix);
      int         fill_w;
      int         pick;
      logic [1:0] action;
      fill_w = (mix == MIX_FILL) ? 40 : (mix == MIX_DRAIN) ? 10 : 25;
      pick   = $urandom_range(0, 99);
      if (pick < fill_w)
         action = ACT_PUSH;
      else if (pick < 50)
         action = ACT_TXRDY;
      else if (pick < 50 + fill_w)
         action = ACT_RECV;
      else
         action = ACT_READ;
      send_item(action, 8'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained();
      while (uart_results_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_directed();
      send_item(ACT_READ, 8'hFF);
      send_item(ACT_TXRDY, 8'hFF);
      send_item(ACT_PUSH, 8'h00);
      send_item(ACT_PUSH, 8'hFF);
      send_item(ACT_PUSH, 8'hA5);
      send_item(ACT_TXRDY, 8'h00);
      send_item(ACT_TXRDY, 8'h00);
      send_item(ACT_TXRDY, 8'h00);
      send_item(ACT_TXRDY, 8'h5A);
      send_item(ACT_PUSH, 8'h80);
      send_item(ACT_RECV, 8'h00);
      send_item(ACT_RECV, 8'hFF);
      send_item(ACT_RECV, 8'h5A);
      send_item(ACT_RECV, 8'h01);
      repeat (5) send_item(ACT_READ, 8'h00);
      send_item(ACT_TXRDY, 8'hFF);
   endtask

   task automatic test_tx_overflow();
      repeat (2) begin
         repeat (SLOTS + 2) send_item(ACT_PUSH, 8'($urandom_range(0, 255)));
         repeat (SLOTS + 1) send_item(ACT_TXRDY, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_rx_overrun();
      repeat (2) begin
         repeat (SLOTS + 2) send_item(ACT_RECV, 8'($urandom_range(0, 255)));
         repeat (SLOTS + 1) send_item(ACT_READ, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_random_traffic();
      traffic_mix_type mix;
      repeat (22) begin
         mix = traffic_mix_type'($urandom_range(0, 2));
         repeat (40) send_random(mix);
      end
   endtask

   task automatic test_rsp_hold_off();
      hold_off_request = 1'b1;
      repeat (24) send_random(MIX_EVEN);
   endtask

   task automatic test_sender_pause();
      repeat (4) begin
         repeat (12) send_random(MIX_EVEN);
         wait_drained();
      end
   endtask

   task automatic test_back_to_back();
      send_gaps_on  = 1'b0;
      rsp_stalls_on = 1'b0;
      repeat (5) begin
         traffic_mix_type mix;
         mix = traffic_mix_type'($urandom_range(0, 2));
         repeat (40) send_random(mix);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_tx_overflow();
      test_rx_overrun();
      test_random_traffic();
      test_rsp_hold_off();
      test_sender_pause();
      test_back_to_back();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      fail_count += uart_results_due.size();
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/urb_pkg.sv
rtl/urb_ctrl.sv
rtl/urb_dpath.sv
rtl/uart_tx_rx_ring_buffer_top.sv
tb/sv/tb_uart_tx_rx_ring_buffer_top.sv
